// ===== hdl/rvc_pkg.sv =====
// ----------------------------------------------------------------------------
// rvc_pkg
// Shared widths, register indexes and controller/datapath command and status types.
// ----------------------------------------------------------------------------
package rvc_pkg;

  localparam int SampleW  = 32;
  localparam int CountW   = 21;
  localparam int SumW     = 52;
  localparam int MeanW    = 31;
  localparam int FlagW    = 4;
  localparam int ModeW    = 5;
  localparam int CfgIdxW  = 3;
  localparam int MaxRecordLenDefault = 1048576;

  localparam logic [CfgIdxW-1:0] RegMode      = 3'd0;
  localparam logic [CfgIdxW-1:0] RegOldMiss   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegNewMiss   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegScale     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegValidMin  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegValidMax  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegMinMean   = 3'd6;
  localparam logic [CfgIdxW-1:0] RegMaxMean   = 3'd7;

  localparam logic KindSample  = 1'b0;
  localparam logic KindSummary = 1'b1;

  // Controller to datapath.
  typedef struct packed {
    logic load;       // capture input item
    logic scale;      // register scaled product
    logic accum;      // update accumulators
    logic div_start;  // load divider
    logic div_step;   // one quotient bit
    logic finish;     // form mean and flags, clear accumulators
    logic clear;      // clear accumulators without summary
  } rvc_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_end;
    logic any_check;
    logic div_done;
  } rvc_status_t;

endpackage

// ===== hdl/rvc_datapath.sv =====
// ----------------------------------------------------------------------------
// rvc_datapath
// Sample conditioning, accumulation and a radix-2 mean divider.
// ----------------------------------------------------------------------------
module rvc_datapath
  import rvc_pkg::*;
#(
  parameter int MAX_RECORD_LEN = MaxRecordLenDefault
) (
  input  logic                      clk,
  input  logic                      rst,
  input  rvc_cmd_t                  cmd,
  output rvc_status_t               status,
  input  logic                      cfg_en,
  input  logic [CfgIdxW-1:0]        cfg_idx,
  input  logic [SampleW-1:0]        cfg_data,
  input  logic signed [SampleW-1:0] sample_in,
  input  logic                      record_end,
  input  logic                      record_has_missing,
  output logic signed [SampleW-1:0] cond_sample,
  output logic [CountW-1:0]         below_cnt,
  output logic [CountW-1:0]         above_cnt,
  output logic [CountW-1:0]         valid_cnt,
  output logic [MeanW-1:0]          mean_val,
  output logic [FlagW-1:0]          flags_val
);

  localparam logic [CountW:0] CapWide = (MAX_RECORD_LEN < (2**CountW - 1)) ?
      (CountW+1)'(MAX_RECORD_LEN) : (CountW+1)'(2**CountW - 1);
  localparam logic [CountW-1:0] CountCap = CapWide[CountW-1:0];
  localparam int DivW = SumW;
  localparam int StepW = $clog2(DivW + 1);
  // Saturation bounds of the running sum, one bit wider than the sum.
  localparam logic signed [SumW:0] SumHi = {2'b00, {(SumW-1){1'b1}}};
  localparam logic signed [SumW:0] SumLo = {2'b11, {(SumW-1){1'b0}}};
  localparam logic [DivW-1:0] MeanMax = {{(DivW-MeanW){1'b0}}, {MeanW{1'b1}}};

  logic [ModeW-1:0]          mode;
  logic signed [SampleW-1:0] old_miss, new_miss, scale_f, vmin, vmax;
  logic [MeanW-1:0]          min_lim, max_lim;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= '0;
      old_miss <= '0;
      new_miss <= '0;
      scale_f  <= 32'sd16777216;
      vmin     <= '0;
      vmax     <= '0;
      min_lim  <= '0;
      max_lim  <= '0;
    end else if (cfg_en) begin
      unique case (cfg_idx)
        RegMode:     mode     <= cfg_data[ModeW-1:0];
        RegOldMiss:  old_miss <= cfg_data;
        RegNewMiss:  new_miss <= cfg_data;
        RegScale:    scale_f  <= cfg_data;
        RegValidMin: vmin     <= cfg_data;
        RegValidMax: vmax     <= cfg_data;
        RegMinMean:  min_lim  <= cfg_data[MeanW-1:0];
        RegMaxMean:  max_lim  <= cfg_data[MeanW-1:0];
        default: ;
      endcase
    end
  end

  // Stage 1: replacement and multiply.
  logic signed [SampleW-1:0] s_rep;
  logic signed [SampleW-1:0] s1;
  logic                      do_scale, is_end;
  logic signed [63:0]        prod;

  always_comb begin
    s_rep = sample_in;
    if (mode[0] && record_has_missing && (sample_in == old_miss)) s_rep = new_miss;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      s1       <= s_rep;
      do_scale <= mode[1] && (s_rep != new_miss);
      is_end   <= record_end;
      prod     <= 64'(s_rep) * 64'(scale_f);
    end
  end

  // Stage 2: round, saturate.
  logic signed [63:0] rnd;
  logic signed [39:0] rsh;
  logic signed [SampleW-1:0] s_scaled;
  always_comb begin
    rnd = prod + 64'sd8388608;
    rsh = rnd[63:24];
    if (rsh > 40'sd2147483647) s_scaled = 32'sh7FFFFFFF;
    else if (rsh < -40'sd2147483648) s_scaled = 32'sh80000000;
    else s_scaled = rsh[31:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.scale) cond_sample <= do_scale ? s_scaled : s1;
  end

  // Accumulators.
  logic signed [SumW-1:0] sum;
  logic signed [SumW:0]   sum_t;
  logic [CountW-1:0]      pcnt, lcnt, hcnt;
  logic                   present;
  assign sum_t   = (SumW+1)'(sum) + (SumW+1)'(cond_sample);
  assign present = cond_sample != new_miss;

  function automatic logic [CountW-1:0] inc(input logic [CountW-1:0] c);
    return (c < CountCap) ? c + 1'b1 : c;
  endfunction

  // Divider: |sum| / pcnt, restoring, one bit per step.
  logic [DivW-1:0]    quo;
  logic [CountW:0]    rem;
  logic [CountW-1:0]  dvs;
  logic [StepW-1:0]   steps;
  logic [CountW:0]    rem_sh, rem_sub;
  assign rem_sh  = {rem[CountW-1:0], quo[DivW-1]};
  assign rem_sub = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0; pcnt <= '0; lcnt <= '0; hcnt <= '0;
    end else if (cmd.accum && present) begin
      if (sum_t > SumHi) sum <= {1'b0, {(SumW-1){1'b1}}};
      else if (sum_t < SumLo) sum <= {1'b1, {(SumW-1){1'b0}}};
      else sum <= sum_t[SumW-1:0];
      pcnt <= inc(pcnt);
      if (cond_sample < vmin) lcnt <= inc(lcnt);
      if (cond_sample > vmax) hcnt <= inc(hcnt);
    end else if (cmd.finish || cmd.clear) begin
      sum <= '0; pcnt <= '0; lcnt <= '0; hcnt <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (cmd.div_start) begin
      quo   <= sum[SumW-1] ? DivW'(-sum) : DivW'(sum);
      rem   <= '0;
      dvs   <= pcnt;
      steps <= StepW'(DivW);
    end else if (cmd.div_step && steps != '0) begin
      if (!rem_sub[CountW]) begin
        rem <= rem_sub;
        quo <= {quo[DivW-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[DivW-2:0], 1'b0};
      end
      steps <= steps - 1'b1;
    end
  end

  // Summary formation.
  logic [MeanW-1:0] mean_sat;
  logic [35:0]      mean10, max10;
  always_comb begin
    if (dvs == '0) mean_sat = '0;
    else if (quo > MeanMax) mean_sat = '1;
    else mean_sat = quo[MeanW-1:0];
    mean10 = 36'(mean_sat) * 36'd10;
    max10  = 36'(max_lim) * 36'd10;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      below_cnt <= lcnt;
      above_cnt <= hcnt;
      valid_cnt <= pcnt;
      mean_val  <= mean_sat;
      flags_val[0] <= mode[3] && (mean10 < 36'(min_lim));
      flags_val[1] <= mode[3] && (mean_sat < min_lim);
      flags_val[2] <= mode[4] && (36'(mean_sat) > max10);
      flags_val[3] <= mode[4] && (mean_sat > max_lim);
    end
  end

  assign status.is_end    = is_end;
  assign status.any_check = mode[4:2] != '0;
  assign status.div_done  = steps == '0;

endmodule

// ===== hdl/rvc_ctrl.sv =====
// ----------------------------------------------------------------------------
// rvc_ctrl
// Sequencer for one item: multiply, scale, emit sample and, at a checked record end, divide and emit summary.
// ----------------------------------------------------------------------------
module rvc_ctrl
  import rvc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic        out_last,
  output rvc_cmd_t    cmd,
  input  rvc_status_t status
);

  typedef enum logic [2:0] {
    Idle, Mult, Scale, EmitSample, DivLoad, DivRun, Finish, EmitSummary
  } state_t;

  state_t state;
  logic   accept;
  assign in_stall = state != Idle;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd = '0;
    cmd.load      = accept;
    cmd.scale     = state == Mult;
    cmd.accum     = state == Scale;
    cmd.clear     = state == EmitSample && !out_stall && status.is_end &&
                    !status.any_check;
    cmd.div_start = state == DivLoad;
    cmd.div_step  = state == DivRun;
    cmd.finish    = state == Finish;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= Idle;
      out_valid <= 1'b0;
      out_kind  <= KindSample;
      out_last  <= 1'b0;
    end else begin
      unique case (state)
        Idle:  if (accept) state <= Mult;
        Mult:  state <= Scale;
        Scale: begin
          state     <= EmitSample;
          out_valid <= 1'b1;
          out_kind  <= KindSample;
          out_last  <= !(status.is_end && status.any_check);
        end
        EmitSample: if (!out_stall) begin
          out_valid <= 1'b0;
          state <= (status.is_end && status.any_check) ? DivLoad : Idle;
        end
        DivLoad: state <= DivRun;
        DivRun:  if (status.div_done) state <= Finish;
        Finish: begin
          state     <= EmitSummary;
          out_valid <= 1'b1;
          out_kind  <= KindSummary;
          out_last  <= 1'b1;
        end
        EmitSummary: if (!out_stall) begin
          out_valid <= 1'b0;
          state     <= Idle;
        end
        default: state <= Idle;
      endcase
    end
  end

endmodule

// ===== hdl/record_value_conditioner_checker_top.sv =====
// ----------------------------------------------------------------------------
// record_value_conditioner_checker_top
// Conditions Q16.16 record samples and checks each record's mean.
// ----------------------------------------------------------------------------
// Each accepted sample is optionally replaced (old missing code to new code)
// and scaled by a Q8.24 factor with round-to-nearest and saturation, then
// returned as a sample item. Non-missing samples are summed and counted. On
// the last sample of a record, when any check is enabled, a summary item
// follows with the counts, the absolute mean and the mean flags. A sample's
// result is offered after the registered multiply and the rounding stage;
// the block takes one item at a time, so a new item is taken only once the
// previous result has been delivered. A record end with checks enabled
// adds a divider load, the bit-serial divider steps that form the mean one
// quotient bit per cycle, forming the summary and offering it.
module record_value_conditioner_checker_top
  import rvc_pkg::*;
#(
  parameter int MAX_RECORD_LEN = MaxRecordLenDefault
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CfgIdxW-1:0]        cfg_index,
  input  logic [SampleW-1:0]        cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [SampleW-1:0] sample_in,
  input  logic                      record_end,
  input  logic                      record_has_missing,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      item_kind,
  output logic signed [SampleW-1:0] sample_out,
  output logic                      run_last,
  output logic [CountW-1:0]         below_count,
  output logic [CountW-1:0]         above_count,
  output logic [CountW-1:0]         valid_count,
  output logic [MeanW-1:0]          mean_abs,
  output logic [FlagW-1:0]          mean_flags
);

  rvc_cmd_t    cmd;
  rvc_status_t status;
  logic signed [SampleW-1:0] cond;
  logic [CountW-1:0] bc, ac, vc;
  logic [MeanW-1:0]  mv;
  logic [FlagW-1:0]  fv;

  rvc_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
    .out_kind(item_kind), .out_last(run_last), .cmd, .status
  );

  rvc_datapath #(.MAX_RECORD_LEN(MAX_RECORD_LEN)) u_dp (
    .clk, .rst, .cmd, .status,
    .cfg_en(cfg_write), .cfg_idx(cfg_index), .cfg_data,
    .sample_in, .record_end, .record_has_missing,
    .cond_sample(cond), .below_cnt(bc), .above_cnt(ac), .valid_cnt(vc),
    .mean_val(mv), .flags_val(fv)
  );

  // Sample items carry only the sample; summaries carry only the statistics.
  logic summ;
  assign summ        = item_kind == KindSummary;
  assign sample_out  = summ ? '0 : cond;
  assign below_count = summ ? bc : '0;
  assign above_count = summ ? ac : '0;
  assign valid_count = summ ? vc : '0;
  assign mean_abs    = summ ? mv : '0;
  assign mean_flags  = summ ? fv : '0;

  // A summary is always the last result of its item.
  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && summ |-> run_last) else $error("summary without last");

  // No new item is taken while a result is pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken during output");

  // A delivered non-last sample item is not directly followed by another sample item.
  a_summary_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !summ && !run_last |=> !(out_valid && !summ))
    else $error("sample after non-last sample");

endmodule
